// ===== sv/plb_pkg.sv =====
// Shared types, register codes and an arithmetic helper for the premultiplied layer
// blend core. No dependencies; all files but plb_mask_if and plb_blend_if import it.
package plb_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes on the configuration channel
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PALETTE_COLOR    = 3'd0,
    CFG_USE_TEXT_COLOR   = 3'd1,
    CFG_HAVE_FOREGROUND  = 3'd2,
    CFG_TEXT_FG          = 3'd3,
    CFG_DARK_BACKGROUND  = 3'd4
  } cfg_idx_e;

  // Packed BGRA word: blue in the low byte, alpha in the high byte
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } bgra_t;

  localparam bgra_t COLOR_WHITE = 32'hFFFF_FFFF;
  localparam bgra_t COLOR_BLACK = 32'hFF00_0000;

  // Truncating x / 255 for x <= 255*255, without a divider
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return s[15:8];
  endfunction

endpackage

// ===== sv/plb_cfg_if.sv =====
// Configuration write channel: register index and write data.
// Depends on plb_pkg for the field widths.
interface plb_cfg_if import plb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/plb_mask_if.sv =====
// Input pixel channel: mask coverage and destination BGRA bytes.
// No dependencies.
interface plb_mask_if ();
  logic       valid;
  logic       ready;
  logic [7:0] coverage;
  logic [7:0] dst_blue;
  logic [7:0] dst_green;
  logic [7:0] dst_red;
  logic [7:0] dst_alpha;

  modport source (output valid, output coverage, output dst_blue, output dst_green,
                  output dst_red, output dst_alpha, input ready);
  modport sink   (input valid, input coverage, input dst_blue, input dst_green,
                  input dst_red, input dst_alpha, output ready);
endinterface

// ===== sv/plb_blend_if.sv =====
// Output pixel channel: composited premultiplied BGRA bytes.
// No dependencies.
interface plb_blend_if ();
  logic       valid;
  logic       ready;
  logic [7:0] out_blue;
  logic [7:0] out_green;
  logic [7:0] out_red;
  logic [7:0] out_alpha;

  modport source (output valid, output out_blue, output out_green, output out_red,
                  output out_alpha, input ready);
  modport sink   (input valid, input out_blue, input out_green, input out_red,
                  input out_alpha, output ready);
endinterface

// ===== sv/plb_cfg.sv =====
// Configuration registers and layer color selection.
// Depends on plb_pkg and plb_cfg_if.
module plb_cfg import plb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  plb_cfg_if.sink    cfg,
  output bgra_t      layer_color
);

  bgra_t palette_color;
  logic  use_text_color;
  logic  have_foreground;
  bgra_t text_fg;
  logic  dark_background;

  // Always take writes; unknown indexes are dropped
  assign cfg.ready = 1'b1;

  // Hold register values, update on a write transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      palette_color    <= '0;
      use_text_color   <= 1'b0;
      have_foreground  <= 1'b0;
      text_fg          <= '0;
      dark_background  <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg_idx_e'(cfg.index))
        CFG_PALETTE_COLOR:    palette_color    <= cfg.data;
        CFG_USE_TEXT_COLOR:   use_text_color   <= cfg.data[0];
        CFG_HAVE_FOREGROUND:  have_foreground  <= cfg.data[0];
        CFG_TEXT_FG:          text_fg          <= cfg.data;
        CFG_DARK_BACKGROUND:  dark_background  <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Pick the layer color: palette, foreground, or white/black fallback
  always_comb begin
    if (!use_text_color) begin
      layer_color = palette_color;
    end else if (have_foreground) begin
      layer_color = text_fg;
    end else if (dark_background) begin
      layer_color = COLOR_WHITE;
    end else begin
      layer_color = COLOR_BLACK;
    end
  end

endmodule

// ===== sv/plb_pipe.sv =====
// Four-stage blend datapath: coverage product, divide, channel products,
// divide and sum. Depends on plb_pkg, plb_mask_if and plb_blend_if.
module plb_pipe import plb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  bgra_t       layer_color,
  plb_mask_if.sink    mask_px,
  plb_blend_if.source blend_px
);

  logic        adv;

  // Stage 1: alpha * coverage
  logic        valid1;
  logic [15:0] cov_prod1;
  bgra_t       color1;
  bgra_t       dst1;

  // Stage 2: layer alpha fa and its complement
  logic        valid2;
  logic [7:0]  fa2;
  logic [7:0]  inv2;
  bgra_t       color2;
  bgra_t       dst2;

  // Stage 3: color * fa and destination * inv
  logic        valid3;
  logic [7:0]  fa3;
  logic [15:0] fc_blue3, fc_green3, fc_red3;
  logic [15:0] dp_blue3, dp_green3, dp_red3, dp_alpha3;

  // Stage 4: output register
  logic        valid4;
  logic [7:0]  out_blue4, out_green4, out_red4, out_alpha4;

  // Advance the whole pipe unless the output holds an untaken transaction
  assign adv           = !valid4 || blend_px.ready;
  assign mask_px.ready = adv;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      valid3 <= 1'b0;
      valid4 <= 1'b0;
    end else if (adv) begin
      valid1 <= mask_px.valid;
      valid2 <= valid1;
      valid3 <= valid2;
      valid4 <= valid3;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (adv) begin
      cov_prod1   <= 16'(layer_color.alpha * mask_px.coverage);
      color1      <= layer_color;
      dst1.blue   <= mask_px.dst_blue;
      dst1.green  <= mask_px.dst_green;
      dst1.red    <= mask_px.dst_red;
      dst1.alpha  <= mask_px.dst_alpha;

      fa2         <= div255(cov_prod1);
      inv2        <= 8'd255 - div255(cov_prod1);
      color2      <= color1;
      dst2        <= dst1;

      fa3         <= fa2;
      fc_blue3    <= 16'(color2.blue  * fa2);
      fc_green3   <= 16'(color2.green * fa2);
      fc_red3     <= 16'(color2.red   * fa2);
      dp_blue3    <= 16'(dst2.blue  * inv2);
      dp_green3   <= 16'(dst2.green * inv2);
      dp_red3     <= 16'(dst2.red   * inv2);
      dp_alpha3   <= 16'(dst2.alpha * inv2);

      out_blue4   <= div255(dp_blue3)  + div255(fc_blue3);
      out_green4  <= div255(dp_green3) + div255(fc_green3);
      out_red4    <= div255(dp_red3)   + div255(fc_red3);
      out_alpha4  <= div255(dp_alpha3) + fa3;
    end
  end

  assign blend_px.valid     = valid4;
  assign blend_px.out_blue  = out_blue4;
  assign blend_px.out_green = out_green4;
  assign blend_px.out_red   = out_red4;
  assign blend_px.out_alpha = out_alpha4;

endmodule

// ===== sv/premultiplied_layer_blend_core.sv =====
// Top level of the premultiplied BGRA layer blend core.
// Depends on plb_pkg, the channel interfaces, plb_cfg and plb_pipe.
//
//   channel   modport  handshake      payload
//   cfg       sink     valid/ready    index, data (register write)
//   mask_px   sink     valid/ready    coverage, dst_blue/green/red/alpha
//   blend_px  source   valid/ready    out_blue/green/red/alpha
//
// One pixel per cycle while blend_px is not stalled; a result passes through the
// four register stages of plb_pipe before it is valid on blend_px.
// Reset (rst, synchronous) clears the configuration registers to 0 and the
// pipe's valid bits, which empties the pipe.
// A stalled output holds the whole pipe; cfg.ready stays high.
module premultiplied_layer_blend_core import plb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  plb_cfg_if.sink     cfg,
  plb_mask_if.sink    mask_px,
  plb_blend_if.source blend_px
);

  bgra_t layer_color;

  plb_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .layer_color (layer_color)
  );

  plb_pipe u_pipe (
    .clk         (clk),
    .rst         (rst),
    .layer_color (layer_color),
    .mask_px     (mask_px),
    .blend_px    (blend_px)
  );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for premultiplied_layer_blend_core: directed and random
// pixel streams checked against an in-bench blend predictor, under varied idling.
// Depends on plb_pkg and the plb_cfg_if, plb_mask_if and plb_blend_if interfaces.
module tb_top import plb_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PIPE_DEPTH   = 4;
  localparam int unsigned LIMIT_CYCLES = 400_000;
  localparam int unsigned RAND_SETS    = 5;
  localparam int unsigned SET_PIXELS   = 50;

  typedef struct packed {
    logic [7:0] coverage;
    logic [7:0] dst_blue;
    logic [7:0] dst_green;
    logic [7:0] dst_red;
    logic [7:0] dst_alpha;
  } mask_px_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic [7:0] out_alpha;
  } blend_px_t;

  logic clk = 1'b0;
  logic rst;

  plb_cfg_if   cfg_ch ();
  plb_mask_if  mask_ch ();
  plb_blend_if blend_ch ();

  premultiplied_layer_blend_core DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_ch.sink),
    .mask_px  (mask_ch.sink),
    .blend_px (blend_ch.source)
  );

  // Shadow copy of the layer color registers
  bgra_t layer_palette;
  logic  text_mode;
  logic  fg_valid;
  bgra_t fg_color;
  logic  dark_bg;

  blend_px_t   blend_expected[$];
  blend_px_t   blend_want;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;

  always #10 clk = ~clk;

  // Composite one pixel over the destination with the current layer color
  function automatic blend_px_t blend_pixel(input mask_px_t px);
    bgra_t       layer;
    int unsigned fa;
    int unsigned inv;
    blend_px_t   res;
    if (text_mode) begin
      if (fg_valid) layer = fg_color;
      else if (dark_bg) layer = COLOR_WHITE;
      else layer = COLOR_BLACK;
    end else begin
      layer = layer_palette;
    end
    fa  = int'(layer.alpha) * int'(px.coverage) / 255;
    inv = 255 - fa;
    res.out_blue  = 8'(int'(px.dst_blue)  * inv / 255 + int'(layer.blue)  * fa / 255);
    res.out_green = 8'(int'(px.dst_green) * inv / 255 + int'(layer.green) * fa / 255);
    res.out_red   = 8'(int'(px.dst_red)   * inv / 255 + int'(layer.red)   * fa / 255);
    res.out_alpha = 8'(int'(px.dst_alpha) * inv / 255 + fa);
    return res;
  endfunction

  // Mirror a register write into the shadow copy; unknown indexes are dropped
  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    case (idx)
      CFG_PALETTE_COLOR:    layer_palette = value;
      CFG_USE_TEXT_COLOR:   text_mode = value[0];
      CFG_HAVE_FOREGROUND:  fg_valid = value[0];
      CFG_TEXT_FG:          fg_color = value;
      CFG_DARK_BACKGROUND:  dark_bg = value[0];
      default: ;
    endcase
  endtask

  // Issue one register write transaction, then hold the channel idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    apply_reg(idx, value);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Send one pixel transaction, with a random idle gap ahead of it
  task automatic send_pixel(input mask_px_t px);
    if ($urandom_range(99) < src_idle_pct) begin
      if (mask_ch.valid) mask_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    mask_ch.valid     <= 1'b1;
    mask_ch.coverage  <= px.coverage;
    mask_ch.dst_blue  <= px.dst_blue;
    mask_ch.dst_green <= px.dst_green;
    mask_ch.dst_red   <= px.dst_red;
    mask_ch.dst_alpha <= px.dst_alpha;
    do @(posedge clk); while (!mask_ch.ready);
    blend_expected.push_back(blend_pixel(px));
  endtask

  // Stop sending and wait until every pending result has come out
  task automatic drain_blend;
    if (mask_ch.valid) mask_ch.valid <= 1'b0;
    while (blend_expected.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  function automatic mask_px_t rand_pixel();
    mask_px_t px;
    case ($urandom_range(9))
      0:       px.coverage = 8'h00;
      1:       px.coverage = 8'hFF;
      default: px.coverage = 8'($urandom);
    endcase
    px.dst_alpha = 8'($urandom);
    // Mostly well-formed premultiplied pixels, some with color above alpha
    if ($urandom_range(3) != 0) begin
      px.dst_blue  = 8'($urandom_range(px.dst_alpha));
      px.dst_green = 8'($urandom_range(px.dst_alpha));
      px.dst_red   = 8'($urandom_range(px.dst_alpha));
    end else begin
      px.dst_blue  = 8'($urandom);
      px.dst_green = 8'($urandom);
      px.dst_red   = 8'($urandom);
    end
    return px;
  endfunction

  // Reset values give a transparent layer: destination passes through
  task automatic test_reset_defaults;
    send_pixel({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    send_pixel({8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    drain_blend();
  endtask

  task automatic test_palette_blend;
    write_reg(CFG_PALETTE_COLOR, 32'hFFFF_FFFF);
    send_pixel({8'hFF, 8'h12, 8'h34, 8'h56, 8'h78});
    send_pixel({8'h00, 8'h80, 8'h81, 8'h82, 8'h83});
    // destination color above its alpha
    send_pixel({8'h80, 8'hFF, 8'hFF, 8'hFF, 8'h10});
    drain_blend();
    write_reg(CFG_PALETTE_COLOR, 32'h80C0_4020);
    send_pixel({8'hFF, 8'hAA, 8'h55, 8'hAA, 8'h55});
    send_pixel({8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    drain_blend();
  endtask

  // Text color: black, then white, then an explicit foreground
  task automatic test_text_color;
    write_reg(CFG_USE_TEXT_COLOR, 32'h0000_0001);
    write_reg(CFG_HAVE_FOREGROUND, 32'h0000_0000);
    write_reg(CFG_DARK_BACKGROUND, 32'h0000_0000);
    send_pixel({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00});
    send_pixel({8'd100, 8'h80, 8'h80, 8'h80, 8'h80});
    drain_blend();
    write_reg(CFG_DARK_BACKGROUND, 32'hABCD_0001);
    send_pixel({8'hFF, 8'h00, 8'h00, 8'h00, 8'h00});
    send_pixel({8'd200, 8'h40, 8'h20, 8'h10, 8'h60});
    drain_blend();
    write_reg(CFG_TEXT_FG, 32'h7F01_FE33);
    write_reg(CFG_HAVE_FOREGROUND, 32'h8000_0003);
    send_pixel({8'hFF, 8'h11, 8'h22, 8'h33, 8'h44});
    send_pixel({8'd77, 8'hF0, 8'h0F, 8'hC3, 8'hFF});
    drain_blend();
  endtask

  // Unused indexes are ignored; flag registers keep only bit 0
  task automatic test_register_decode;
    for (int i = CFG_DARK_BACKGROUND + 1; i < 2 ** CFG_IDX_W; i++) begin
      write_reg(i[CFG_IDX_W-1:0], 32'hFFFF_FFFF);
    end
    write_reg(CFG_USE_TEXT_COLOR, 32'hFFFF_FFFE);
    send_pixel({8'hFF, 8'h00, 8'h00, 8'h00, 8'h00});
    send_pixel({8'hFE, 8'h9C, 8'h3A, 8'h77, 8'hE1});
    drain_blend();
  endtask

  // Load a full register setting: all zero, all one, or random with wide flag words
  task automatic program_setting(input int unsigned sel);
    logic [CFG_DATA_W-1:0] pal, fg, txt, hfg, dark;
    if (sel == 0) begin
      {pal, fg, txt, hfg, dark} = '0;
    end else if (sel == 1) begin
      {pal, fg, txt, hfg, dark} = '1;
    end else begin
      pal  = $urandom;
      fg   = $urandom;
      txt  = $urandom;
      hfg  = $urandom;
      dark = $urandom;
      if ($urandom_range(3) == 0) pal[31:24] = {8{pal[0]}};
      if ($urandom_range(3) == 0) fg[31:24]  = {8{fg[0]}};
    end
    write_reg(CFG_PALETTE_COLOR, pal);
    write_reg(CFG_USE_TEXT_COLOR, txt);
    write_reg(CFG_HAVE_FOREGROUND, hfg);
    write_reg(CFG_TEXT_FG, fg);
    write_reg(CFG_DARK_BACKGROUND, dark);
    if ($urandom_range(2) == 0) begin
      write_reg(CFG_IDX_W'(CFG_DARK_BACKGROUND + 1 + $urandom_range(2)), $urandom);
    end
  endtask

  // Random stream under one idling mode; pause for a full drain between settings
  task automatic test_random_stream(input int unsigned idle_pct, input int unsigned stall_pct);
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    for (int unsigned s = 0; s < RAND_SETS; s++) begin
      program_setting(s);
      for (int unsigned n = 0; n < SET_PIXELS; n++) begin
        send_pixel(rand_pixel());
      end
      drain_blend();
    end
  endtask

  // Drive stimulus: reset, directed cases, then random traffic per idling mode
  initial begin
    rst               <= 1'b1;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= '0;
    cfg_ch.data       <= '0;
    mask_ch.valid     <= 1'b0;
    mask_ch.coverage  <= '0;
    mask_ch.dst_blue  <= '0;
    mask_ch.dst_green <= '0;
    mask_ch.dst_red   <= '0;
    mask_ch.dst_alpha <= '0;
    layer_palette = '0;
    text_mode     = 1'b0;
    fg_valid      = 1'b0;
    fg_color      = '0;
    dark_bg       = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_palette_blend();
    test_text_color();
    test_register_decode();
    test_random_stream(0, 0);
    test_random_stream(67, 0);
    test_random_stream(0, 67);
    test_random_stream(27, 27);

    drain_blend();
    if (mismatch_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    blend_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (!rst && blend_ch.valid && blend_ch.ready) begin
      if (blend_expected.size() == 0) begin
        $display("%0t ns: unexpected result, expected none actual %h_%h_%h_%h", $time,
                 blend_ch.out_alpha, blend_ch.out_red, blend_ch.out_green, blend_ch.out_blue);
        mismatch_count++;
      end else begin
        blend_want = blend_expected.pop_front();
        check_field("out_blue",  blend_want.out_blue,  blend_ch.out_blue);
        check_field("out_green", blend_want.out_green, blend_ch.out_green);
        check_field("out_red",   blend_want.out_red,   blend_ch.out_red);
        check_field("out_alpha", blend_want.out_alpha, blend_ch.out_alpha);
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
sv/plb_pkg.sv
sv/plb_cfg_if.sv
sv/plb_mask_if.sv
sv/plb_blend_if.sv
sv/plb_cfg.sv
sv/plb_pipe.sv
sv/premultiplied_layer_blend_core.sv
tb/tb_top.sv
